>>> rtl/phi_pkg.sv
`timescale 1ns / 1ps
// package: shared types and constants of the pose history interpolator
package phi_pkg;

	localparam int DVD_W = 64;
	localparam int DVS_W = 32;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_QUERY = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	localparam logic [2:0] STAT_INTERP  = 3'd0;
	localparam logic [2:0] STAT_PRED    = 3'd1;
	localparam logic [2:0] STAT_FAR     = 3'd2;
	localparam logic [2:0] STAT_OLD     = 3'd3;
	localparam logic [2:0] STAT_NODATA  = 3'd4;
	localparam logic [2:0] STAT_STORED  = 3'd5;
	localparam logic [2:0] STAT_CLEARED = 3'd6;

	localparam logic [1:0] CFG_DEPTH = 2'd0;
	localparam logic [1:0] CFG_MS    = 2'd1;
	localparam logic [1:0] CFG_PCT   = 2'd2;

	localparam logic [1:0] FLD_X    = 2'd0;
	localparam logic [1:0] FLD_Y    = 2'd1;
	localparam logic [1:0] FLD_DH   = 2'd2;
	localparam logic [1:0] FLD_WRAP = 2'd3;

	localparam logic [31:0] SPAN_DEFAULT = 32'd100;
	localparam logic [31:0] FULL_TURN    = 32'd23040;

	typedef enum logic [1:0] {
		MODE_EXACT,
		MODE_INTERP,
		MODE_PRED
	} mode_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ADD,
		S_CLEAR,
		S_QSTART,
		S_SRD,
		S_SCHK,
		S_RD1,
		S_GOT1,
		S_SPAN,
		S_CHK1,
		S_CHK2,
		S_PSETUP,
		S_MUL0,
		S_MUL1,
		S_DSTART,
		S_DIV,
		S_POST,
		S_OUT
	} state_t;

	typedef struct packed {
		logic [31:0]        t;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [14:0] h;
	} entry_t;

	typedef struct packed {
		logic       in_take;
		logic       mem_wr;
		logic       ptr_clr;
		logic       age_clr;
		logic       age_next;
		logic       rd_go;
		logic       srch_take;
		logic       oth_take;
		logic       span_go;
		logic       chk_go;
		logic       setup_go;
		logic       mul_lo;
		logic       mul_hi;
		logic       div_start;
		logic       post_go;
		logic       out_load;
		mode_t      mode;
		logic [1:0] fld;
		logic [2:0] res_status;
		logic       res_near;
		logic       res_pose;
	} ctrl_cmd_t;

	typedef struct packed {
		logic fill_zero;
		logic fill_lt2;
		logic age_zero;
		logic age_last;
		logic found;
		logic exact;
		logic far;
		logic div_done;
		logic out_free;
	} dp_stat_t;

endpackage

>>> rtl/pose_history_interpolator_core.sv
`timescale 1ns / 1ps
// add and clear: accept, then S_ADD or S_CLEAR, then S_OUT loads the result beat; next beat accepted after that
// the query time is set by the 64-step serial divider, run once for each of x, y and
// heading delta, plus a read per walked reading (S_SRD, S_SCHK) and a short heading wrap fold
// one beat in flight; a new beat is taken while the previous result waits
// reset is asynchronous: empty history, depth 64, ms limit off, percent limit 5000
module pose_history_interpolator_core
	import phi_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         cmd,
	input  logic [31:0]        stamp_ms,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [14:0] pose_heading,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [14:0] out_heading,
	output logic [31:0]        near_stamp_ms,
	output logic signed [31:0] near_x,
	output logic signed [31:0] near_y,
	output logic signed [14:0] near_heading
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	phi_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_cmd   (cmd),
		.stat     (stat),
		.ctl      (ctl),
		.in_stall (in_stall)
	);

	phi_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.stamp_ms      (stamp_ms),
		.pose_x        (pose_x),
		.pose_y        (pose_y),
		.pose_heading  (pose_heading),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_heading   (out_heading),
		.near_stamp_ms (near_stamp_ms),
		.near_x        (near_x),
		.near_y        (near_y),
		.near_heading  (near_heading)
	);

endmodule

>>> rtl/phi_div.sv
`timescale 1ns / 1ps
// module: serial restoring divider, one quotient bit per cycle
module phi_div
	import phi_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic [DVD_W-1:0] quotient,
	output logic             done
);

	logic [DVD_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W-1:0] rem_q;
	logic [$clog2(DVD_W)-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [DVS_W:0] r_sh;
	logic           ge;
	logic [DVS_W:0] r_sub;

	always_comb begin
		r_sh  = {rem_q, dvd_q[DVD_W-1]};
		ge    = (r_sh >= {1'b0, dvs_q});
		r_sub = r_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == '1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
			rem_q <= ge ? r_sub[DVS_W-1:0] : r_sh[DVS_W-1:0];
		end
	end

	assign quotient  = dvd_q;
	assign done      = done_q;

endmodule

>>> rtl/phi_dp.sv
`timescale 1ns / 1ps
// module: datapath with history memory, search registers and projection arithmetic
module phi_dp
	import phi_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ctrl_cmd_t          ctl,
	output dp_stat_t           stat,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic [31:0]        stamp_ms,
	input  logic signed [31:0] pose_x,
	input  logic signed [31:0] pose_y,
	input  logic signed [14:0] pose_heading,
	input  logic               out_stall,
	output logic               out_valid,
	output logic [2:0]         status,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [14:0] out_heading,
	output logic [31:0]        near_stamp_ms,
	output logic signed [31:0] near_x,
	output logic signed [31:0] near_y,
	output logic signed [14:0] near_heading
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW:0]   DEPTH_W   = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] DEPTH_C   = CW'(DEPTH);
	localparam logic [CW-1:0] DEPTH_RST = CW'((DEPTH < 64) ? DEPTH : 64);
	localparam logic signed [63:0] OFF_MAX = 64'sd1 << 40;
	localparam logic signed [63:0] OFF_MIN = -(64'sd1 << 40);
	localparam logic signed [41:0] SAT_HI  = 42'sd2147483647;
	localparam logic signed [41:0] SAT_LO  = -42'sd2147483648;

	entry_t mem_q [DEPTH];
	entry_t rd_q, near_q, prv_q, oth_q, new_q;
	logic [31:0] qstamp_q;
	logic [AW-1:0] newest_q, age_q;
	logic [CW-1:0] fill_q, depth_q;
	logic signed [31:0] ams_q;
	logic signed [17:0] apct_q;
	logic signed [31:0] num_q, den_q;
	logic signed [38:0] p1_q;
	logic signed [49:0] p2_q;
	logic [32:0] am_q;
	logic [31:0] nm_q, dvs_q;
	logic neg_q;
	logic [63:0] prod_q;
	logic signed [31:0] rx_q, ry_q;
	logic signed [47:0] qh_q;
	logic signed [14:0] rh_q;
	logic [13:0] wsum_q;
	logic [14:0] wrem_q;
	logic out_valid_q;

	logic [CW-1:0] dep_new;
	logic [AW-1:0] nxt_slot, rd_slot;
	logic [AW:0]   sl_sum;
	logic [31:0]   tdf;

	// configuration decode
	always_comb begin
		if (cfg_data[6:0] == 7'd0) begin
			dep_new = CW'(1);
		end else if (int'(cfg_data[6:0]) > DEPTH) begin
			dep_new = DEPTH_C;
		end else begin
			dep_new = CW'(cfg_data[6:0]);
		end
	end

	always_comb begin
		nxt_slot = (newest_q == AW'(DEPTH - 1)) ? '0 : newest_q + AW'(1);
		sl_sum   = {1'b0, newest_q} + DEPTH_W - {1'b0, age_q};
		rd_slot  = (sl_sum >= DEPTH_W) ? AW'(sl_sum - DEPTH_W) : AW'(sl_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q  <= DEPTH_RST;
			ams_q    <= -32'sd1;
			apct_q   <= 18'sd5000;
			fill_q   <= '0;
			newest_q <= '0;
			age_q    <= '0;
		end else begin
			if (cfg_we && cfg_index == CFG_DEPTH) depth_q <= dep_new;
			if (cfg_we && cfg_index == CFG_MS) ams_q <= $signed(cfg_data);
			if (cfg_we && cfg_index == CFG_PCT) apct_q <= $signed(cfg_data[17:0]);
			if (ctl.ptr_clr) begin
				fill_q   <= '0;
				newest_q <= '0;
			end else if (ctl.mem_wr) begin
				newest_q <= nxt_slot;
				if (fill_q < depth_q) fill_q <= fill_q + CW'(1);
			end else if (cfg_we && cfg_index == CFG_DEPTH && fill_q > dep_new) begin
				fill_q <= dep_new;
			end
			if (ctl.age_clr) begin
				age_q <= '0;
			end else if (ctl.age_next) begin
				age_q <= age_q + AW'(1);
			end
		end
	end

	// history memory
	always_ff @(posedge clk) begin
		if (ctl.mem_wr) mem_q[nxt_slot] <= new_q;
		if (ctl.rd_go) rd_q <= mem_q[rd_slot];
	end

	always_ff @(posedge clk) begin
		if (ctl.in_take) begin
			qstamp_q <= stamp_ms;
			new_q    <= '{t: stamp_ms, x: pose_x, y: pose_y, h: pose_heading};
		end
		if (ctl.srch_take) begin
			near_q <= rd_q;
			prv_q  <= near_q;
		end
		if (ctl.oth_take) oth_q <= rd_q;
	end

	// span and limit checks
	logic [31:0] to_d, tot_d;
	logic signed [32:0] nx, nmag, dx, dmag;
	logic signed [49:0] p1x;
	logic far_pct, far_ms;

	always_comb begin
		to_d = qstamp_q - near_q.t;
		case (ctl.mode)
			MODE_PRED:   tot_d = near_q.t - oth_q.t;
			MODE_INTERP: tot_d = prv_q.t - near_q.t;
			default:     tot_d = SPAN_DEFAULT;
		endcase
		nx      = 33'(num_q);
		nmag    = nx[32] ? -nx : nx;
		dx      = 33'(den_q);
		dmag    = dx[32] ? -dx : dx;
		p1x     = 50'(p1_q);
		far_pct = !apct_q[17] && (den_q[31] ? (p1x < p2_q) : (p1x > p2_q));
		far_ms  = !ams_q[31] && (nmag > 33'(ams_q));
	end

	always_ff @(posedge clk) begin
		if (ctl.span_go) begin
			num_q <= (ctl.mode == MODE_EXACT) ? 32'sd0 : $signed(to_d);
			den_q <= (tot_d == 32'd0) ? $signed(SPAN_DEFAULT) : $signed(tot_d);
		end
		if (ctl.chk_go) begin
			p1_q <= 39'(num_q) * 39'sd100;
			p2_q <= 50'(apct_q) * 50'(den_q);
		end
	end

	// projection setup
	entry_t ef, et;
	logic signed [32:0] ax, ay, a_sel;
	logic signed [16:0] dh;
	logic [32:0] amag;
	logic signed [47:0] hv;
	logic [63:0] hmag;
	logic [48:0] pp;

	always_comb begin
		ef = (ctl.mode == MODE_PRED) ? oth_q : near_q;
		et = (ctl.mode == MODE_INTERP) ? prv_q : near_q;
		ax = 33'(et.x) - 33'(ef.x);
		ay = 33'(et.y) - 33'(ef.y);
		dh = 17'(et.h) - 17'(ef.h);
		if (dh >= 17'sd23040) dh = dh - 17'sd23040;
		if (dh <= -17'sd23040) dh = dh + 17'sd23040;
		if (dh > 17'sd11520) dh = dh - 17'sd23040;
		if (dh <= -17'sd11520) dh = dh + 17'sd23040;
		case (ctl.fld)
			FLD_X:   a_sel = ax;
			FLD_Y:   a_sel = ay;
			default: a_sel = 33'(dh);
		endcase
		amag = a_sel[32] ? $unsigned(-a_sel) : $unsigned(a_sel);
		hv   = 48'(near_q.h) + qh_q;
		hmag = 64'($unsigned(hv[47] ? -hv : hv));
		pp   = am_q * 49'(ctl.mul_hi ? nm_q[31:16] : nm_q[15:0]);
	end

	always_ff @(posedge clk) begin
		if (ctl.setup_go) begin
			if (ctl.fld == FLD_WRAP) begin
				prod_q <= hmag;
				dvs_q  <= FULL_TURN;
				neg_q  <= hv[47];
			end else begin
				am_q  <= amag;
				nm_q  <= nmag[31:0];
				dvs_q <= dmag[31:0];
				neg_q <= a_sel[32] ^ num_q[31] ^ den_q[31];
			end
		end else if (ctl.mul_lo && ctl.fld != FLD_WRAP) begin
			prod_q <= 64'(pp);
		end else if (ctl.mul_hi && ctl.fld != FLD_WRAP) begin
			prod_q <= prod_q + {pp[47:0], 16'b0};
		end
	end

	// heading wrap: 23040 = 45 * 512 and 4096 mod 45 = 1, so fold 12-bit chunks
	logic [12:0] wv;
	logic [25:0] wp;
	logic [7:0]  wq;
	logic [12:0] wr;

	always_comb begin
		wv = 13'(wsum_q[11:0]) + 13'(wsum_q[13:12]);
		wp = 26'(wv) * 26'(13'd5826);
		wq = wp[25:18];
		wr = wv - 13'(wq) * 13'd45;
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_lo && ctl.fld == FLD_WRAP) begin
			wsum_q <= 14'(prod_q[20:9]) + 14'(prod_q[32:21]) + 14'(prod_q[44:33])
				+ 14'(prod_q[56:45]);
		end
		if (ctl.mul_hi && ctl.fld == FLD_WRAP) begin
			wrem_q <= {wr[5:0], prod_q[8:0]};
		end
	end

	logic [63:0] quo;
	logic div_done;

	phi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (ctl.div_start),
		.dividend  (prod_q),
		.divisor   (dvs_q),
		.quotient  (quo),
		.done      (div_done)
	);

	// quotient finish
	logic signed [63:0] qs;
	logic signed [41:0] qc, sum;
	logic signed [31:0] sat;
	logic signed [16:0] rw;

	always_comb begin
		qs = neg_q ? -$signed(quo) : $signed(quo);
		if (qs > OFF_MAX) begin
			qc = 42'(OFF_MAX);
		end else if (qs < OFF_MIN) begin
			qc = 42'(OFF_MIN);
		end else begin
			qc = 42'(qs);
		end
		sum = 42'((ctl.fld == FLD_X) ? near_q.x : near_q.y) + qc;
		if (sum > SAT_HI) begin
			sat = 32'sh7fffffff;
		end else if (sum < SAT_LO) begin
			sat = -32'sh80000000;
		end else begin
			sat = 32'(sum);
		end
		rw = $signed({2'b00, wrem_q});
		if (neg_q) rw = -rw;
		if (rw > 17'sd11520) rw = rw - 17'sd23040;
		if (rw <= -17'sd11520) rw = rw + 17'sd23040;
	end

	always_ff @(posedge clk) begin
		if (ctl.post_go) begin
			case (ctl.fld)
				FLD_X:   rx_q <= sat;
				FLD_Y:   ry_q <= sat;
				FLD_DH:  qh_q <= 48'(qs);
				default: rh_q <= 15'(rw);
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.out_load) begin
			status        <= ctl.res_status;
			out_x         <= ctl.res_pose ? rx_q : 32'sd0;
			out_y         <= ctl.res_pose ? ry_q : 32'sd0;
			out_heading   <= ctl.res_pose ? rh_q : 15'sd0;
			near_stamp_ms <= ctl.res_near ? near_q.t : 32'd0;
			near_x        <= ctl.res_near ? near_q.x : 32'sd0;
			near_y        <= ctl.res_near ? near_q.y : 32'sd0;
			near_heading  <= ctl.res_near ? near_q.h : 15'sd0;
		end
	end

	assign out_valid = out_valid_q;
	assign tdf       = qstamp_q - rd_q.t;

	always_comb begin
		stat.fill_zero = (fill_q == '0);
		stat.fill_lt2  = (fill_q < CW'(2));
		stat.age_zero  = (age_q == '0);
		stat.age_last  = ((CW'(age_q) + CW'(1)) == fill_q);
		stat.found     = !tdf[31];
		stat.exact     = (qstamp_q == rd_q.t);
		stat.far       = far_pct || far_ms;
		stat.div_done  = div_done;
		stat.out_free  = !out_valid_q || !out_stall;
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= depth_q)
		else $error("fill count above kept depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> (!out_valid_q || !out_stall))
		else $error("result beat overwritten");

	a_wr_rd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.mem_wr |-> !ctl.rd_go && !ctl.ptr_clr)
		else $error("history write collides with read or clear");

endmodule

>>> rtl/phi_ctrl.sv
`timescale 1ns / 1ps
// module: sequencing state machine for add, clear and query
module phi_ctrl
	import phi_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic [1:0] in_cmd,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  ctl,
	output logic       in_stall
);

	state_t state_q, state_d;
	mode_t mode_q, mode_d;
	logic mode_set;
	logic [1:0] fld_q;
	logic [2:0] res_status_q, res_st_d;
	logic res_near_q, res_pose_q, res_near_d, res_pose_d, res_set;

	always_comb begin
		state_d    = state_q;
		res_set    = 1'b0;
		res_st_d   = STAT_STORED;
		res_near_d = 1'b0;
		res_pose_d = 1'b0;
		mode_set   = 1'b0;
		mode_d     = MODE_EXACT;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					case (in_cmd)
						CMD_ADD:   state_d = S_ADD;
						CMD_QUERY: state_d = S_QSTART;
						CMD_CLEAR: state_d = S_CLEAR;
						default:   state_d = S_IDLE;
					endcase
				end
			end
			S_ADD: begin
				res_set  = 1'b1;
				res_st_d = STAT_STORED;
				state_d  = S_OUT;
			end
			S_CLEAR: begin
				res_set  = 1'b1;
				res_st_d = STAT_CLEARED;
				state_d  = S_OUT;
			end
			S_QSTART: begin
				if (stat.fill_zero) begin
					res_set  = 1'b1;
					res_st_d = STAT_OLD;
					state_d  = S_OUT;
				end else begin
					state_d = S_SRD;
				end
			end
			S_SRD: state_d = S_SCHK;
			S_SCHK: begin
				if (stat.found) begin
					if (!stat.age_zero) begin
						mode_set = 1'b1;
						mode_d   = MODE_INTERP;
						state_d  = S_SPAN;
					end else if (stat.exact) begin
						mode_set = 1'b1;
						mode_d   = MODE_EXACT;
						state_d  = S_SPAN;
					end else if (stat.fill_lt2) begin
						res_set    = 1'b1;
						res_st_d   = STAT_NODATA;
						res_near_d = 1'b1;
						state_d    = S_OUT;
					end else begin
						state_d = S_RD1;
					end
				end else if (stat.age_last) begin
					res_set    = 1'b1;
					res_st_d   = STAT_OLD;
					res_near_d = 1'b1;
					state_d    = S_OUT;
				end else begin
					state_d = S_SRD;
				end
			end
			S_RD1: state_d = S_GOT1;
			S_GOT1: begin
				mode_set = 1'b1;
				mode_d   = MODE_PRED;
				state_d  = S_SPAN;
			end
			S_SPAN: state_d = (mode_q == MODE_PRED) ? S_CHK1 : S_PSETUP;
			S_CHK1: state_d = S_CHK2;
			S_CHK2: begin
				if (stat.far) begin
					res_set    = 1'b1;
					res_st_d   = STAT_FAR;
					res_near_d = 1'b1;
					state_d    = S_OUT;
				end else begin
					state_d = S_PSETUP;
				end
			end
			S_PSETUP: state_d = S_MUL0;
			S_MUL0:   state_d = S_MUL1;
			S_MUL1:   state_d = (fld_q == FLD_WRAP) ? S_POST : S_DSTART;
			S_DSTART: state_d = S_DIV;
			S_DIV:    state_d = stat.div_done ? S_POST : S_DIV;
			S_POST: begin
				if (fld_q == FLD_WRAP) begin
					res_set    = 1'b1;
					res_st_d   = (mode_q == MODE_PRED) ? STAT_PRED : STAT_INTERP;
					res_near_d = 1'b1;
					res_pose_d = 1'b1;
					state_d    = S_OUT;
				end else begin
					state_d = S_PSETUP;
				end
			end
			S_OUT:   state_d = stat.out_free ? S_IDLE : S_OUT;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl            = '0;
		ctl.mode       = mode_q;
		ctl.fld        = fld_q;
		ctl.res_status = res_status_q;
		ctl.res_near   = res_near_q;
		ctl.res_pose   = res_pose_q;
		case (state_q)
			S_IDLE:   ctl.in_take = in_valid;
			S_ADD:    ctl.mem_wr = 1'b1;
			S_CLEAR:  ctl.ptr_clr = 1'b1;
			S_QSTART: ctl.age_clr = 1'b1;
			S_SRD:    ctl.rd_go = 1'b1;
			S_SCHK: begin
				ctl.srch_take = 1'b1;
				ctl.age_next  = !stat.found || stat.age_zero;
			end
			S_RD1:    ctl.rd_go = 1'b1;
			S_GOT1:   ctl.oth_take = 1'b1;
			S_SPAN:   ctl.span_go = 1'b1;
			S_CHK1:   ctl.chk_go = 1'b1;
			S_PSETUP: ctl.setup_go = 1'b1;
			S_MUL0:   ctl.mul_lo = 1'b1;
			S_MUL1:   ctl.mul_hi = 1'b1;
			S_DSTART: ctl.div_start = 1'b1;
			S_POST:   ctl.post_go = 1'b1;
			S_OUT:    ctl.out_load = stat.out_free;
			default:  ctl.in_take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			mode_q       <= MODE_EXACT;
			fld_q        <= FLD_X;
			res_status_q <= STAT_STORED;
			res_near_q   <= 1'b0;
			res_pose_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (mode_set) mode_q <= mode_d;
			if (state_q == S_SPAN) begin
				fld_q <= FLD_X;
			end else if (state_q == S_POST) begin
				fld_q <= fld_q + 2'd1;
			end
			if (res_set) begin
				res_status_q <= res_st_d;
				res_near_q   <= res_near_d;
				res_pose_q   <= res_pose_d;
			end
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

>>> tb/sv/tb_pose_history_interpolator_core.sv
`timescale 1ns / 1ps
// testbench: pose history interpolator core checked beat by beat against a built-in predictor
module tb_pose_history_interpolator_core;
	import phi_pkg::*;

	typedef struct {
		logic [2:0]         st;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [14:0] h;
		logic [31:0]        nt;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [14:0] nh;
	} pose_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         cmd;
	logic [31:0]        stamp_ms;
	logic signed [31:0] pose_x;
	logic signed [31:0] pose_y;
	logic signed [14:0] pose_heading;
	logic               out_valid;
	logic               out_stall;
	logic [2:0]         status;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [14:0] out_heading;
	logic [31:0]        near_stamp_ms;
	logic signed [31:0] near_x;
	logic signed [31:0] near_y;
	logic signed [14:0] near_heading;

	pose_history_interpolator_core uut (.*);

	// predictor state
	logic [31:0]        hist_t [64];
	logic signed [31:0] hist_x [64];
	logic signed [31:0] hist_y [64];
	logic signed [14:0] hist_h [64];
	int unsigned        fill_cnt;
	int unsigned        newest;
	int unsigned        keep_depth;
	longint             lim_ms;
	longint             lim_pct;

	pose_result_t pending_poses[$];
	int           errors;
	int           hold_left;
	bit           steady;
	logic [31:0]  clock_ms;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic longint tdiff(logic [31:0] a, logic [31:0] b);
		logic [31:0] d;
		d = a - b;
		return longint'($signed(d));
	endfunction

	function automatic longint wrap_h(longint v);
		longint r;
		r = v % 23040;
		if (r > 11520) r -= 23040;
		if (r <= -11520) r += 23040;
		return r;
	endfunction

	function automatic int unsigned slot_of(int unsigned age);
		return (newest + 64 - age) % 64;
	endfunction

	function automatic logic signed [31:0] blend(longint base, longint from, longint to,
			longint num, longint den);
		longint q;
		longint s;
		q = ((to - from) * num) / den;
		if (q > (longint'(1) <<< 40)) q = longint'(1) <<< 40;
		if (q < -(longint'(1) <<< 40)) q = -(longint'(1) <<< 40);
		s = base + q;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic void project(inout pose_result_t r, input int unsigned b, f, t,
			input longint num, den);
		longint dh;
		longint hv;
		r.x = blend(hist_x[b], hist_x[f], hist_x[t], num, den);
		r.y = blend(hist_y[b], hist_y[f], hist_y[t], num, den);
		dh = wrap_h(longint'(hist_h[t]) - longint'(hist_h[f]));
		hv = wrap_h(longint'(hist_h[b]) + (dh * num) / den);
		r.h = hv[14:0];
	endfunction

	task automatic predict_beat(logic [1:0] c, logic [31:0] q, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [14:0] ph);
		pose_result_t r;
		int unsigned  i, k, s, s1, sl;
		bit           found;
		longint       total, to;
		bit           far;
		r = '{default: 0};
		if (c == CMD_NOP) return;
		if (c == CMD_ADD) begin
			newest = (newest + 1) % 64;
			hist_t[newest] = q;
			hist_x[newest] = px;
			hist_y[newest] = py;
			hist_h[newest] = ph;
			if (fill_cnt < keep_depth) fill_cnt++;
			r.st = STAT_STORED;
			pending_poses.push_back(r);
			return;
		end
		if (c == CMD_CLEAR) begin
			fill_cnt = 0;
			newest = 0;
			r.st = STAT_CLEARED;
			pending_poses.push_back(r);
			return;
		end
		found = 0;
		k = 0;
		for (i = 0; i < fill_cnt && !found; i++) begin
			if (tdiff(q, hist_t[slot_of(i)]) >= 0) begin
				found = 1;
				k = i;
			end
		end
		if (fill_cnt == 0) begin
			r.st = STAT_OLD;
			pending_poses.push_back(r);
			return;
		end
		s = slot_of(found ? k : fill_cnt - 1);
		r.nt = hist_t[s];
		r.nx = hist_x[s];
		r.ny = hist_y[s];
		r.nh = hist_h[s];
		if (!found) begin
			r.st = STAT_OLD;
		end else if (k == 0 && q != hist_t[s]) begin
			if (fill_cnt < 2) begin
				r.st = STAT_NODATA;
			end else begin
				s1 = slot_of(1);
				total = tdiff(hist_t[s], hist_t[s1]);
				if (total == 0) total = 100;
				to = tdiff(q, hist_t[s]);
				far = 0;
				if (lim_pct >= 0)
					far = total > 0 ? (to * 100 > lim_pct * total) : (to * 100 < lim_pct * total);
				if (lim_ms >= 0 && (to < 0 ? -to : to) > lim_ms) far = 1;
				if (far) begin
					r.st = STAT_FAR;
				end else begin
					project(r, s, s1, s, to, total);
					r.st = STAT_PRED;
				end
			end
		end else if (k == 0) begin
			project(r, s, s, s, 0, 100);
			r.st = STAT_INTERP;
		end else begin
			sl = slot_of(k - 1);
			total = tdiff(hist_t[sl], hist_t[s]);
			if (total == 0) total = 100;
			to = tdiff(q, hist_t[s]);
			project(r, s, s, sl, to, total);
			r.st = STAT_INTERP;
		end
		pending_poses.push_back(r);
	endtask

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		pose_result_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_poses.size() == 0) begin
				report("unexpected beat, status", status, -1);
			end else begin
				e = pending_poses.pop_front();
				if (status !== e.st) report("status", status, e.st);
				if (out_x !== e.x) report("out_x", out_x, e.x);
				if (out_y !== e.y) report("out_y", out_y, e.y);
				if (out_heading !== e.h) report("out_heading", out_heading, e.h);
				if (near_stamp_ms !== e.nt) report("near_stamp_ms", near_stamp_ms, e.nt);
				if (near_x !== e.nx) report("near_x", near_x, e.nx);
				if (near_y !== e.ny) report("near_y", near_y, e.ny);
				if (near_heading !== e.nh) report("near_heading", near_heading, e.nh);
			end
		end
	end

	// receiver stall
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 28);
		end
	end

	task automatic send_beat(logic [1:0] c, logic [31:0] q, logic signed [31:0] px,
			logic signed [31:0] py, logic signed [14:0] ph);
		int gap;
		if (!steady && $urandom_range(99) < 28) begin
			gap = $urandom_range(1, 6);
			@(negedge clk);
			in_valid = 0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1;
		cmd = c;
		stamp_ms = q;
		pose_x = px;
		pose_y = py;
		pose_heading = ph;
		do @(posedge clk); while (in_stall);
		predict_beat(c, q, px, py, ph);
	endtask

	task automatic add_pose(logic [31:0] q, logic signed [31:0] px, logic signed [31:0] py,
			logic signed [14:0] ph);
		send_beat(CMD_ADD, q, px, py, ph);
	endtask

	task automatic query_at(logic [31:0] q);
		send_beat(CMD_QUERY, q, $urandom, $urandom, 0);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid = 0;
		while (pending_poses.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		logic [6:0] d;
		drain();
		@(negedge clk);
		cfg_we = 1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 0;
		if (idx == CFG_DEPTH) begin
			d = val[6:0];
			keep_depth = d < 1 ? 1 : (d > 64 ? 64 : d);
			if (fill_cnt > keep_depth) fill_cnt = keep_depth;
		end else if (idx == CFG_MS) begin
			lim_ms = longint'($signed(val));
		end else if (idx == CFG_PCT) begin
			lim_pct = longint'($signed(val[17:0]));
		end
	endtask

	function automatic logic signed [14:0] rand_heading();
		int v;
		v = int'($urandom_range(23039)) - 11519;
		return v[14:0];
	endfunction

	task automatic test_directed();
		send_beat(CMD_CLEAR, 0, 0, 0, 0);
		query_at(32'h0000_1000);
		add_pose(1000, 32'sh7fff_ffff, -32'sh8000_0000, 15'sd11520);
		query_at(1000);
		query_at(1050);
		query_at(999);
		add_pose(1100, -32'sh8000_0000, 32'sh7fff_ffff, -15'sd11519);
		query_at(1050);
		query_at(1150);
		query_at(7000);
		add_pose(1100, 100, 200, 15'sd11000);
		query_at(1120);
		add_pose(1050, 0, 0, -15'sd11000);
		query_at(1060);
		query_at(32'hffff_fff0);
		send_beat(CMD_NOP, 5, 5, 5, 5);
		add_pose(32'hffff_ff00, 1, 2, 3);
		add_pose(32'h0000_0010, 17, 18, 19);
		query_at(32'h0000_0000);
		query_at(32'h0000_0020);
		send_beat(CMD_CLEAR, 0, 0, 0, 0);
		query_at(5);
	endtask

	task automatic test_limits();
		write_reg(CFG_MS, 30);
		write_reg(CFG_PCT, 32'h0003_ffff);
		add_pose(2000, 0, 0, 0);
		add_pose(2100, 1600, -1600, 640);
		query_at(2120);
		query_at(2140);
		write_reg(CFG_PCT, 100000);
		write_reg(CFG_MS, 32'h7fff_ffff);
		query_at(2200);
		query_at(32'h0100_0000);
		write_reg(CFG_PCT, 0);
		query_at(2101);
		write_reg(2'd3, 32'h1234_5678);
		write_reg(CFG_DEPTH, 0);
		query_at(2050);
		query_at(2200);
		write_reg(CFG_DEPTH, 127);
		write_reg(CFG_PCT, 5000);
		write_reg(CFG_MS, 32'hffff_ffff);
	endtask

	task automatic random_beat();
		int          p;
		logic [31:0] q;
		p = $urandom_range(99);
		if (p < 12) begin
			case ($urandom_range(3))
				0: send_beat(CMD_ADD, $urandom, $urandom, $urandom, rand_heading());
				1: send_beat(CMD_QUERY, $urandom, $urandom, $urandom, rand_heading());
				2: send_beat(CMD_NOP, $urandom, $urandom, $urandom, rand_heading());
				default: send_beat(CMD_CLEAR, $urandom, $urandom, $urandom, rand_heading());
			endcase
		end else if (p < 14) begin
			send_beat(CMD_CLEAR, clock_ms, 0, 0, 0);
		end else if (p < 55) begin
			clock_ms += ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 80);
			if ($urandom_range(7) == 0)
				add_pose(clock_ms, $urandom, $urandom, rand_heading());
			else
				add_pose(clock_ms, int'($urandom_range(4000)) - 2000,
					int'($urandom_range(4000)) - 2000, rand_heading());
		end else begin
			q = clock_ms + $urandom_range(300) - 240;
			if ($urandom_range(9) == 0) q = clock_ms - $urandom_range(5000);
			query_at(q);
		end
	endtask

	task automatic test_random(int count);
		repeat (count) random_beat();
	endtask

	task automatic test_backpressure();
		steady = 1;
		hold_left = 300;
		repeat (8) random_beat();
		steady = 0;
		drain();
		repeat (10) random_beat();
	endtask

	task automatic test_steady();
		steady = 1;
		repeat (40) random_beat();
		steady = 0;
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_index = CFG_DEPTH;
		cfg_data = 0;
		in_valid = 0;
		cmd = CMD_NOP;
		stamp_ms = 0;
		pose_x = 0;
		pose_y = 0;
		pose_heading = 0;
		out_stall = 0;
		hold_left = 0;
		steady = 0;
		errors = 0;
		fill_cnt = 0;
		newest = 0;
		keep_depth = 64;
		lim_ms = -1;
		lim_pct = 5000;
		clock_ms = $urandom;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_directed();
		test_limits();
		test_random(90);
		test_backpressure();
		write_reg(CFG_DEPTH, 1);
		test_random(40);
		write_reg(CFG_DEPTH, $urandom_range(2, 12));
		write_reg(CFG_MS, $urandom_range(500));
		write_reg(CFG_PCT, $urandom_range(300));
		test_random(80);
		write_reg(CFG_PCT, 32'hffff_ffff);
		write_reg(CFG_MS, 32'hffff_ffff);
		test_steady();
		write_reg(CFG_DEPTH, 64);
		write_reg(CFG_PCT, 100000);
		write_reg(CFG_MS, 32'h7fff_ffff);
		test_random(110);

		drain();
		repeat (400) @(posedge clk);
		if (errors == 0 && pending_poses.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule
